// ===== rtl/nvt_pkg.sv =====
`timescale 1ns / 1ps

package nvt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int NAME_BYTES  = 8;
    localparam int KEY_W       = 64;
    localparam int VALUE_W     = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic FN_LOOKUP = 1'b0;
    localparam logic FN_ADD    = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // name ends at its first zero byte and after NAME_BYTES bytes
    function automatic logic [KEY_W-1:0] canon_name(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] out;
        logic             alive;
        out   = '0;
        alive = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (b >= NAME_BYTES || key[8*b +: 8] == 8'h00) begin
                alive = 1'b0;
            end
            if (alive) begin
                out[8*b +: 8] = key[8*b +: 8];
            end
        end
        return out;
    endfunction

endpackage

// ===== rtl/named_value_table_lookup_insert_core.sv =====
`timescale 1ns / 1ps

// named value table: linear search key/value store with one shared comparator
//
// command channel: present i_func, i_name_key and i_new_value with start; the
// command transfers at a clock edge where start is high and busy is low.
// i_func selects lookup or add/update. names are cut at the first zero byte.
// result channel: o_status and o_read_value are shown for one cycle with
// o_valid high; the receiver cannot hold them off.
// a search reads one stored name per cycle from the newest entry down, and
// busy stays high until the search hits or has compared every entry in
// use, so a command ends early on a hit. an add to a full table or a
// lookup/add on an empty table answers in the cycle after the transfer and
// leaves busy low.
// each stored name passes the registered table read port, then the name comparator.
// reset (synchronous, active low) empties the table; stored contents are not
// cleared, only the fill count.
module named_value_table_lookup_insert_core
    import nvt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_func,
    input  logic [KEY_W-1:0]   i_name_key,
    input  logic [VALUE_W-1:0] i_new_value,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [VALUE_W-1:0] o_read_value
);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_left, n_left;
    logic [IDX_W-1:0]   r_addr, n_addr;
    logic               r_pend, n_pend;
    logic               r_func, n_func;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [VALUE_W-1:0] r_val, n_val;
    logic               r_valid, n_valid;
    t_status            r_status, n_status;
    logic [VALUE_W-1:0] r_rdout, n_rdout;

    logic [KEY_W-1:0]   mem_names [TABLE_DEPTH];
    logic [VALUE_W-1:0] mem_vals  [TABLE_DEPTH];
    logic [KEY_W-1:0]   r_rd_name;
    logic [VALUE_W-1:0] r_rd_val;
    logic [IDX_W-1:0]   r_rd_idx;

    logic               we_name, we_val;
    logic [IDX_W-1:0]   wr_addr;
    logic [KEY_W-1:0]   wr_name;
    logic [VALUE_W-1:0] wr_val;

    logic               accept;
    logic [KEY_W-1:0]   in_key;
    logic [CNT_W-1:0]   count_m1;
    logic [IDX_W-1:0]   count_idx;

    assign accept    = start && (r_state == S_IDLE);
    assign in_key    = canon_name(i_name_key);
    assign count_m1  = r_count - CNT_W'(1);
    assign count_idx = r_count[IDX_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_left   = r_left;
        n_addr   = r_addr;
        n_pend   = r_pend;
        n_func   = r_func;
        n_key    = r_key;
        n_val    = r_val;
        n_valid  = 1'b0;
        n_status = r_status;
        n_rdout  = r_rdout;
        we_name  = 1'b0;
        we_val   = 1'b0;
        wr_addr  = count_idx;
        wr_name  = r_key;
        wr_val   = r_val;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func = i_func;
                    n_key  = in_key;
                    n_val  = i_new_value;
                    n_addr = count_m1[IDX_W-1:0];
                    n_left = r_count;
                    n_pend = 1'b0;
                    if (i_func == FN_ADD && r_count >= CNT_W'(TABLE_DEPTH)) begin
                        n_valid  = 1'b1;
                        n_status = ST_FULL;
                        n_rdout  = '0;
                    end else if (r_count == '0) begin
                        n_valid = 1'b1;
                        n_rdout = '0;
                        if (i_func == FN_LOOKUP) begin
                            n_status = ST_NOT_FOUND;
                        end else begin
                            n_status = ST_OK;
                            we_name  = 1'b1;
                            we_val   = 1'b1;
                            wr_name  = in_key;
                            wr_val   = i_new_value;
                            n_count  = r_count + CNT_W'(1);
                        end
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                priority if (r_pend && r_rd_name == r_key) begin
                    // hit on the newest matching entry
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_IDLE;
                    if (r_func == FN_LOOKUP) begin
                        n_rdout = r_rd_val;
                    end else begin
                        n_rdout = '0;
                        we_val  = 1'b1;
                        wr_addr = r_rd_idx;
                    end
                end else if (r_left != '0) begin
                    n_left = r_left - CNT_W'(1);
                    n_addr = r_addr - IDX_W'(1);
                    n_pend = 1'b1;
                end else begin
                    // every entry compared without a hit
                    n_valid = 1'b1;
                    n_rdout = '0;
                    n_state = S_IDLE;
                    if (r_func == FN_LOOKUP) begin
                        n_status = ST_NOT_FOUND;
                    end else begin
                        n_status = ST_OK;
                        we_name  = 1'b1;
                        we_val   = 1'b1;
                        n_count  = r_count + CNT_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_valid  <= 1'b0;
            r_pend   <= 1'b0;
            r_left   <= '0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_valid  <= n_valid;
            r_pend   <= n_pend;
            r_left   <= n_left;
            r_status <= n_status;
        end
        r_addr  <= n_addr;
        r_func  <= n_func;
        r_key   <= n_key;
        r_val   <= n_val;
        r_rdout <= n_rdout;
    end

    // table storage, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (we_name) begin
            mem_names[wr_addr] <= wr_name;
        end
        if (we_val) begin
            mem_vals[wr_addr] <= wr_val;
        end
        r_rd_name <= mem_names[r_addr];
        r_rd_val  <= mem_vals[r_addr];
        r_rd_idx  <= r_addr;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_read_value = r_rdout;

endmodule
